### hw/rtl/bayer_weighted_gray_filter_unit_defines.svh
// Assertion macros shared by the Bayer luma filter RTL.
// Included by every module that carries concurrent assertions; needs signals named clock and reset.
`ifndef BAYER_WEIGHTED_GRAY_FILTER_UNIT_DEFINES_SVH
`define BAYER_WEIGHTED_GRAY_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BWGF_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BWGF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/bwgf_pkg.sv
// Shared types and constants of the Bayer luma filter.
// No dependencies; used by bwgf_rsp_fifo and bayer_weighted_gray_filter_unit.
`timescale 1ns / 1ps

package bwgf_pkg;

   // Configuration register indexes and port widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN      = 2'd2;

   // Register reset values.
   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;
   localparam logic [12:0] HEIGHT_MIN   = 13'd3;
   localparam logic [12:0] HEIGHT_MAX   = 13'd4096;

   // Color weights in 1/256 units; green is halved since a quad has two greens.
   localparam logic [6:0] WT_R = 7'd76;
   localparam logic [6:0] WT_G = 7'd75;
   localparam logic [6:0] WT_B = 7'd29;

   // Weight per {pattern, row parity, column parity}.
   localparam logic [6:0] WEIGHT_TABLE [16] = '{
      WT_R, WT_G, WT_G, WT_B,   // RGGB
      WT_G, WT_B, WT_R, WT_G,   // GBRG
      WT_G, WT_R, WT_B, WT_G,   // GRBG
      WT_B, WT_G, WT_G, WT_R    // BGGR
   };

   // Response queue depth; a power of two so the pointers wrap on their own.
   localparam int RSP_FIFO_DEPTH = 8;

   // One result item.
   typedef struct packed {
      logic [7:0] gray;
      logic       last_of_run;
   } rsp_item_type;

   // Up to two result items pushed into the response queue in one cycle.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

   // Status of the response queue seen by the filter datapath.
   typedef struct packed {
      logic room;
      logic not_empty;
   } rsp_status_type;

endpackage

### hw/rtl/bwgf_rsp_fifo.sv
// Response queue of the Bayer luma filter: takes up to two results a cycle, gives one.
// Depends on bwgf_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "bayer_weighted_gray_filter_unit_defines.svh"

module bwgf_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  bwgf_pkg::rsp_push_type        push,
   input  logic                          pop,
   output bwgf_pkg::rsp_item_type        head,
   output bwgf_pkg::rsp_status_type      status
);
   import bwgf_pkg::*;

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);
   // Room is kept for the request in flight plus the one about to be taken.
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(RSP_FIFO_DEPTH - 4);

   rsp_item_type     entry_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] free_slots;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage: the second item goes one slot after the first.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

   assign head             = entry_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.room      = (count_ff <= ROOM_LIMIT);
   assign free_slots       = CNT_W'(RSP_FIFO_DEPTH) - count_ff;

   `BWGF_ASSERT_IMPLIES(a_fifo_bound, 1'b1, count_ff <= CNT_W'(RSP_FIFO_DEPTH), "queue overfilled")
   `BWGF_ASSERT_IMPLIES(a_fifo_push_fits, push.count != 2'd0, CNT_W'(push.count) <= free_slots, "push into full queue")
   `BWGF_ASSERT_NEXT(a_fifo_hold, !pop && push.count == 2'd0, $stable(count_ff), "count moved while idle")

endmodule

### hw/rtl/bayer_weighted_gray_filter_unit.sv
// Top level of the Bayer mosaic to 8-bit luma filter.
// Depends on bwgf_pkg, bwgf_rsp_fifo and the shared assertion macro header.
`timescale 1ns / 1ps
`include "bayer_weighted_gray_filter_unit_defines.svh"

// Takes one raw Bayer sample per cycle while req_stall is low, in raster order, and returns
// luma in raster order, one result per cycle while rsp_stall is low, through an eight-entry
// response queue. A request is taken in every cycle in which req_stall is low; its results
// are pushed into the queue from the stage one registers (the line store read and the
// horizontal products are registered at acceptance, then the vertical sum feeds the queue).
// Row 0 gives one zero per sample, row 1 gives nothing, later rows give the previous row's
// output with zero borders, so a row's last sample gives two results. req_stall rises
// while the queue holds more than four results, and after reset while the line store is
// cleared (configuration writes are taken throughout). The line store is one single-port-read,
// single-port-write memory of MAX_WIDTH 32-bit words holding the two previous rows'
// horizontal sums. Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module bayer_weighted_gray_filter_unit #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bwgf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bwgf_pkg::CSR_DATA_W-1:0]      csr_data,
   // Raw sample requests.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_raw_pixel,
   // Luma results.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_gray,
   output logic                                 rsp_last_of_run
);
   import bwgf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW_W  = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (EW_W > 12) ? EW_W : 12;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ZERO,
      KIND_PIX,
      KIND_PIX_EDGE
   } kind_type;

   // Configuration registers.
   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic [1:0]  pattern_ff;

   // Position and sample history.
   logic [COL_W-1:0] col_ff, col_in;
   logic [11:0]      row_ff, row_in;
   logic [7:0]       prev_one_ff;
   logic [7:0]       prev_two_ff;

   // Line store clearing pass.
   logic             clear_active_ff;
   logic [COL_W-1:0] clear_addr_ff;

   // Stage one registers.
   logic             s1_valid_ff;
   kind_type         s1_kind_ff;
   logic             s1_wr_en_ff;
   logic             s1_wr_zero_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic [14:0]      s1_prod_a_ff;
   logic [14:0]      s1_prod_b_ff;
   logic [31:0]      rd_data_ff;

   logic [31:0]      line_store [MAX_WIDTH];

   // Stage zero decode.
   logic             req_accept;
   logic [CMP_W-1:0] width_ext;
   logic [CMP_W-1:0] width_clamp;
   logic [EW_W-1:0]  eff_width;
   logic [12:0]      eff_height;
   logic [EW_W-1:0]  col_ext;
   logic [COL_W-1:0] c_eff;
   logic [11:0]      r_eff;
   logic [EW_W-1:0]  col_next;
   logic             col_wrap;
   logic [12:0]      row_next;
   kind_type         kind;
   logic             wr_en;
   logic             wr_zero;
   logic [COL_W-1:0] wr_addr;
   logic [COL_W-1:0] rd_addr;
   logic [6:0]       weight_one;
   logic [6:0]       weight_two;
   logic [15:0]      prod_a_full;
   logic [14:0]      prod_a;
   logic [14:0]      prod_b;

   // Stage one compute.
   logic [15:0]      t_sum;
   logic [15:0]      m_one;
   logic [15:0]      m_two;
   logic [16:0]      vert_sum;
   logic [16:0]      mid_sum;
   logic [8:0]       gray_wide;
   logic [7:0]       gray_sat;
   logic             mem_we;
   logic [COL_W-1:0] mem_wa;
   logic [31:0]      mem_wd;

   rsp_push_type     push;
   rsp_item_type     head;
   rsp_status_type   fifo_status;
   logic             rsp_pop;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         pattern_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff   <= csr_data[11:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_data;
            CSR_PATTERN:      pattern_ff <= csr_data[1:0];
            default:          ;
         endcase
      end
   end

   // Effective frame size, clamped to the supported range.
   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ext < CMP_W'(3)) begin
         width_clamp = CMP_W'(3);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_clamp = CMP_W'(MAX_WIDTH);
      end else begin
         width_clamp = width_ext;
      end
      eff_width = EW_W'(width_clamp);
      if (height_ff < HEIGHT_MIN) begin
         eff_height = HEIGHT_MIN;
      end else if (height_ff > HEIGHT_MAX) begin
         eff_height = HEIGHT_MAX;
      end else begin
         eff_height = height_ff;
      end
   end

   // Current position; an out-of-range column is taken as the last one.
   always_comb begin
      col_ext  = EW_W'(col_ff);
      c_eff    = (col_ext >= eff_width) ? COL_W'(eff_width - EW_W'(1)) : col_ff;
      r_eff    = (13'(row_ff) >= eff_height) ? 12'd0 : row_ff;
      col_next = EW_W'(c_eff) + EW_W'(1);
      col_wrap = (col_next >= eff_width);
      row_next = 13'(r_eff) + 13'd1;
      col_in   = col_wrap ? '0 : COL_W'(col_next);
      if (col_wrap) begin
         row_in = (row_next >= eff_height) ? 12'd0 : row_next[11:0];
      end else begin
         row_in = r_eff;
      end
   end

   // Result kind and line store access of the incoming request.
   always_comb begin
      kind    = KIND_NONE;
      wr_en   = 1'b0;
      wr_zero = 1'b0;
      wr_addr = c_eff;
      rd_addr = c_eff - COL_W'(1);
      if (r_eff < 12'd2) begin
         wr_en   = 1'b1;
         wr_zero = 1'b1;
         if (r_eff == 12'd0) begin
            kind = KIND_ZERO;
         end
      end else if (c_eff == COL_W'(1)) begin
         kind = KIND_ZERO;
      end else if (c_eff >= COL_W'(2)) begin
         wr_en   = 1'b1;
         wr_addr = c_eff - COL_W'(1);
         if (EW_W'(c_eff) == eff_width - EW_W'(1)) begin
            kind = KIND_PIX_EDGE;
         end else begin
            kind = KIND_PIX;
         end
      end
   end

   // Horizontal filter products: outer taps share one half weight, center tap full weight.
   always_comb begin
      weight_one  = WEIGHT_TABLE[{pattern_ff, r_eff[0], c_eff[0]}];
      weight_two  = WEIGHT_TABLE[{pattern_ff, r_eff[0], ~c_eff[0]}];
      prod_a_full = (9'(prev_two_ff) + 9'(req_raw_pixel)) * weight_one;
      prod_a      = prod_a_full[15:1];
      prod_b      = prev_one_ff * weight_two;
   end

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = clear_active_ff || !fifo_status.room;

   // Position, history and stage one registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff          <= '0;
         row_ff          <= '0;
         prev_one_ff     <= '0;
         prev_two_ff     <= '0;
         s1_valid_ff     <= 1'b0;
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         s1_valid_ff <= req_accept;
         if (req_accept) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            prev_two_ff <= prev_one_ff;
            prev_one_ff <= req_raw_pixel;
         end
         if (clear_active_ff) begin
            clear_addr_ff <= clear_addr_ff + COL_W'(1);
            if (clear_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
               clear_active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff    <= kind;
         s1_wr_en_ff   <= wr_en;
         s1_wr_zero_ff <= wr_zero;
         s1_addr_ff    <= wr_addr;
         s1_prod_a_ff  <= prod_a;
         s1_prod_b_ff  <= prod_b;
      end
   end

   // Vertical filter: half of the outer rows plus the middle row, then scaled down.
   always_comb begin
      t_sum     = 16'(s1_prod_a_ff) + 16'(s1_prod_b_ff);
      m_one     = rd_data_ff[15:0];
      m_two     = rd_data_ff[31:16];
      vert_sum  = 17'(m_two) + 17'(t_sum);
      mid_sum   = 17'(vert_sum[16:1]) + 17'(m_one);
      gray_wide = mid_sum[16:8];
      gray_sat  = (gray_wide > 9'd255) ? 8'd255 : gray_wide[7:0];
   end

   // Line store write: the clearing pass, or the row shift of the request in stage one.
   always_comb begin
      mem_we = clear_active_ff || (s1_valid_ff && s1_wr_en_ff);
      mem_wa = clear_active_ff ? clear_addr_ff : s1_addr_ff;
      mem_wd = (clear_active_ff || s1_wr_zero_ff) ? 32'd0 : {m_one, t_sum};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store[mem_wa] <= mem_wd;
      end
      if (req_accept) begin
         rd_data_ff <= line_store[rd_addr];
      end
   end

   // Results of the request in stage one.
   always_comb begin
      push.count              = 2'd0;
      push.first.gray         = 8'd0;
      push.first.last_of_run  = 1'b1;
      push.second.gray        = 8'd0;
      push.second.last_of_run = 1'b1;
      if (s1_valid_ff) begin
         case (s1_kind_ff)
            KIND_ZERO: begin
               push.count = 2'd1;
            end
            KIND_PIX: begin
               push.count      = 2'd1;
               push.first.gray = gray_sat;
            end
            KIND_PIX_EDGE: begin
               push.count             = 2'd2;
               push.first.gray        = gray_sat;
               push.first.last_of_run = 1'b0;
            end
            default: begin
               push.count = 2'd0;
            end
         endcase
      end
   end

   bwgf_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_pop),
      .head   (head),
      .status (fifo_status)
   );

   assign rsp_valid       = fifo_status.not_empty;
   assign rsp_pop         = rsp_valid && !rsp_stall;
   assign rsp_gray        = head.gray;
   assign rsp_last_of_run = head.last_of_run;

   `BWGF_ASSERT_IMPLIES(a_clear_no_work, clear_active_ff, !s1_valid_ff, "request in flight during clear")
   `BWGF_ASSERT_NEXT(a_accept_to_s1, req_accept, s1_valid_ff, "accepted request lost before stage one")
   `BWGF_ASSERT_IMPLIES(a_pix_writes_sum, s1_valid_ff && (s1_kind_ff == KIND_PIX || s1_kind_ff == KIND_PIX_EDGE), s1_wr_en_ff && !s1_wr_zero_ff, "pixel result without row shift")

endmodule
